// File: hdl/tce_pkg.sv
// Shared types and constants for the text column extractor.
// No dependencies; every other file in hdl/ imports this package.
package tce_pkg;

    localparam int DEF_RANGE_SLOTS = 8;
    localparam int DEF_POS_WIDTH   = 16;

    localparam int BYTE_W   = 8;
    localparam int RANGE_W  = 16;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [BYTE_W-1:0]  NEWLINE_BYTE  = 8'd10;
    localparam logic [BYTE_W-1:0]  DELIM_RESET   = 8'd9;
    localparam logic [RANGE_W-1:0] OPEN_END      = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_MODE   = 3'd0,
        CFG_DELIMITER    = 3'd1,
        CFG_RANGE_COUNT  = 3'd2,
        CFG_RANGE_PAIR_A = 3'd3,
        CFG_RANGE_PAIR_B = 3'd4,
        CFG_RANGE_PAIR_C = 3'd5,
        CFG_RANGE_PAIR_D = 3'd6
    } t_cfg_index;

    // One inclusive range; the start sits in the low half of the word.
    typedef struct packed {
        logic [RANGE_W-1:0] hi;
        logic [RANGE_W-1:0] lo;
    } t_range;

    // Outcome of one byte through the line filter.
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data;
    } t_decision;

endpackage

// File: hdl/tce_cfg_regs.sv
// Configuration register file for the text column extractor.
// Depends on tce_pkg.
module tce_cfg_regs #(
    parameter int RANGE_SLOTS = tce_pkg::DEF_RANGE_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [tce_pkg::CFG_IDX_W-1:0]      i_wr_index,
    input  logic [tce_pkg::CFG_DATA_W-1:0]     i_wr_data,
    output logic                               o_field_mode,
    output logic [tce_pkg::BYTE_W-1:0]         o_delimiter,
    output logic [tce_pkg::COUNT_W-1:0]        o_active_count,
    output tce_pkg::t_range                    o_ranges [RANGE_SLOTS]
);
    import tce_pkg::*;

    logic                r_field_mode;
    logic [BYTE_W-1:0]   r_delimiter;
    logic [COUNT_W-1:0]  r_range_count;
    t_range              r_ranges [RANGE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_mode  <= 1'b0;
            r_delimiter   <= DELIM_RESET;
            r_range_count <= '0;
        end else if (i_wr_en) begin
            if (i_wr_index == CFG_FIELD_MODE) begin
                r_field_mode <= i_wr_data[0];
            end
            if (i_wr_index == CFG_DELIMITER) begin
                r_delimiter <= i_wr_data[BYTE_W-1:0];
            end
            if (i_wr_index == CFG_RANGE_COUNT) begin
                r_range_count <= i_wr_data[COUNT_W-1:0];
            end
        end
    end

    // Each pair register carries two ranges; only those the design holds are kept.
    for (genvar k = 0; k < RANGE_SLOTS; k++) begin : g_range
        localparam logic [CFG_IDX_W-1:0] PairIdx =
            CFG_IDX_W'(int'(CFG_RANGE_PAIR_A) + k / 2);
        localparam int Lsb = (k % 2) * 32;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ranges[k] <= '0;
            end else if (i_wr_en && i_wr_index == PairIdx) begin
                r_ranges[k] <= i_wr_data[Lsb +: 32];
            end
        end
        assign o_ranges[k] = r_ranges[k];
    end

    assign o_field_mode   = r_field_mode;
    assign o_delimiter    = r_delimiter;
    assign o_active_count = (r_range_count > COUNT_W'(RANGE_SLOTS))
                            ? COUNT_W'(RANGE_SLOTS) : r_range_count;

endmodule

// File: hdl/tce_range_match.sv
// Parallel compare of one position against all active inclusive ranges.
// Depends on tce_pkg.
module tce_range_match #(
    parameter int RANGE_SLOTS = tce_pkg::DEF_RANGE_SLOTS,
    parameter int POS_WIDTH   = tce_pkg::DEF_POS_WIDTH
) (
    input  logic [POS_WIDTH-1:0]           i_pos,
    input  logic [tce_pkg::COUNT_W-1:0]    i_active_count,
    input  tce_pkg::t_range                i_ranges [RANGE_SLOTS],
    output logic                           o_hit
);
    import tce_pkg::*;

    localparam int CmpW = (POS_WIDTH > RANGE_W) ? POS_WIDTH : RANGE_W;

    logic [RANGE_SLOTS-1:0] hits;
    logic [CmpW-1:0]        pos_ext;

    assign pos_ext = CmpW'(i_pos);

    for (genvar k = 0; k < RANGE_SLOTS; k++) begin : g_cmp
        logic above_lo;
        logic below_hi;
        assign above_lo = pos_ext >= CmpW'(i_ranges[k].lo);
        assign below_hi = (i_ranges[k].hi == OPEN_END) || (pos_ext <= CmpW'(i_ranges[k].hi));
        assign hits[k]  = (COUNT_W'(k) < i_active_count) && above_lo && below_hi;
    end

    assign o_hit = |hits;

endmodule

// File: hdl/tce_line_filter.sv
// Line state (position or field counter, selected-field flag) and the
// per-byte pass decision. Depends on tce_pkg and tce_range_match.
module tce_line_filter #(
    parameter int RANGE_SLOTS = tce_pkg::DEF_RANGE_SLOTS,
    parameter int POS_WIDTH   = tce_pkg::DEF_POS_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [tce_pkg::BYTE_W-1:0]     i_byte,
    input  logic                           i_field_mode,
    input  logic [tce_pkg::BYTE_W-1:0]     i_delimiter,
    input  logic [tce_pkg::COUNT_W-1:0]    i_active_count,
    input  tce_pkg::t_range                i_ranges [RANGE_SLOTS],
    output tce_pkg::t_decision             o_decision
);
    import tce_pkg::*;

    localparam logic [POS_WIDTH-1:0] PosMax = '1;

    logic [POS_WIDTH-1:0] r_counter, n_counter;
    logic                 r_seen_sel, n_seen_sel;
    logic [POS_WIDTH-1:0] cur_pos;
    logic [POS_WIDTH-1:0] next_pos;
    logic                 hit_cur;
    logic                 hit_next;
    logic                 prior;

    // The bumped counter equals the current position, both saturating.
    assign cur_pos  = (r_counter == PosMax) ? PosMax : r_counter + 1'b1;
    assign next_pos = (cur_pos == PosMax) ? PosMax : cur_pos + 1'b1;

    tce_range_match #(.RANGE_SLOTS(RANGE_SLOTS), .POS_WIDTH(POS_WIDTH)) u_match_cur (
        .i_pos          (cur_pos),
        .i_active_count (i_active_count),
        .i_ranges       (i_ranges),
        .o_hit          (hit_cur)
    );

    tce_range_match #(.RANGE_SLOTS(RANGE_SLOTS), .POS_WIDTH(POS_WIDTH)) u_match_next (
        .i_pos          (next_pos),
        .i_active_count (i_active_count),
        .i_ranges       (i_ranges),
        .o_hit          (hit_next)
    );

    assign prior = r_seen_sel || hit_cur;

    always_comb begin
        n_counter       = r_counter;
        n_seen_sel      = r_seen_sel;
        o_decision.emit = 1'b0;
        o_decision.data = i_byte;
        priority if (i_byte == NEWLINE_BYTE) begin
            n_counter       = '0;
            n_seen_sel      = 1'b0;
            o_decision.emit = 1'b1;
        end else if (!i_field_mode) begin
            n_counter       = cur_pos;
            o_decision.emit = hit_cur;
        end else if (i_byte == i_delimiter) begin
            n_counter       = cur_pos;
            n_seen_sel      = prior;
            o_decision.emit = hit_next && prior;
        end else begin
            o_decision.emit = hit_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_seen_sel <= 1'b0;
        end else if (i_step) begin
            r_counter  <= n_counter;
            r_seen_sel <= n_seen_sel;
        end
    end

endmodule

// File: hdl/text_column_extractor.sv
// Top level of the text column extractor: input register, line filter, result register.
// Depends on tce_pkg, tce_cfg_regs, tce_line_filter and tce_range_match.
//
//   Channel  | Direction | Handshake                  | Payload
//   ---------+-----------+----------------------------+------------------------------
//   in       | sink      | i_in_valid / o_in_ready    | i_in_byte (8 bits)
//   out      | source    | o_out_valid / i_out_ready  | o_out_byte (8 bits)
//   cfg      | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index (3), i_cfg_data (64)
//
// Each byte passes from the input register through the range compares into the result
// register. One byte is taken every cycle while the output is not stalled; the rate is
// set by the single pass through the two parallel range comparators.
// Reset is synchronous and active low, clears the line state and the valid flags, and
// resets the configuration registers. A stalled output holds the result register and the
// input register, and the input side stops taking bytes once the input register is full.
module text_column_extractor #(
    parameter int RANGE_SLOTS = tce_pkg::DEF_RANGE_SLOTS,
    parameter int POS_WIDTH   = tce_pkg::DEF_POS_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tce_pkg::BYTE_W-1:0]      i_in_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tce_pkg::BYTE_W-1:0]      o_out_byte,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tce_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tce_pkg::*;

    logic                 field_mode;
    logic [BYTE_W-1:0]    delimiter;
    logic [COUNT_W-1:0]   active_count;
    t_range               ranges [RANGE_SLOTS];

    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 advance;
    t_decision            decision;

    // Configuration writes are always taken; the register file applies them at once.
    assign o_cfg_ready = 1'b1;

    tce_cfg_regs #(.RANGE_SLOTS(RANGE_SLOTS)) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (i_cfg_valid),
        .i_wr_index     (i_cfg_index),
        .i_wr_data      (i_cfg_data),
        .o_field_mode   (field_mode),
        .o_delimiter    (delimiter),
        .o_active_count (active_count),
        .o_ranges       (ranges)
    );

    // The held byte moves on whenever the result register is free or being emptied.
    // A byte that yields no result still moves on and updates the line state.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    tce_line_filter #(.RANGE_SLOTS(RANGE_SLOTS), .POS_WIDTH(POS_WIDTH)) u_filter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_byte         (r_in_byte),
        .i_field_mode   (field_mode),
        .i_delimiter    (delimiter),
        .i_active_count (active_count),
        .i_ranges       (ranges),
        .o_decision     (decision)
    );

    // Result register: loaded on every advance, cleared once its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= decision.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= decision.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

endmodule
